// ===== rtl/memory_card_sector_protocol_unit_assert.svh =====
// Assertion helpers for the checker file.
`ifndef MEMORY_CARD_SECTOR_PROTOCOL_UNIT_ASSERT_SVH
`define MEMORY_CARD_SECTOR_PROTOCOL_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MCSPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MCSPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mcspu_pkg.sv =====
`default_nettype none
package mcspu_pkg;

  localparam int SECTOR_BYTES = 128;
  localparam int SECTOR_COUNT = 1024;
  localparam int STORE_DEPTH  = SECTOR_BYTES * SECTOR_COUNT;
  localparam int SECT_W       = $clog2(SECTOR_COUNT);
  localparam int OFF_W        = $clog2(SECTOR_BYTES);
  localparam int STORE_AW     = SECT_W + OFF_W;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  // Command bytes
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] CMD_STATUS = 8'h53;

  // Reply bytes
  localparam logic [7:0] RPL_ID1   = 8'h5a;
  localparam logic [7:0] RPL_ID2   = 8'h5d;
  localparam logic [7:0] RPL_ACK1  = 8'h5c;
  localparam logic [7:0] RPL_ACK2  = 8'h5d;
  localparam logic [7:0] RPL_GOOD  = 8'h47;
  localparam logic [7:0] RPL_BAD   = 8'hff;
  localparam logic [7:0] RPL_ZERO  = 8'h00;
  localparam logic [7:0] RPL_SIZE  = 8'h04;
  localparam logic [7:0] RPL_TAIL  = 8'h80;

  localparam logic [7:0] FLAG_RESET      = 8'h08;
  localparam logic [7:0] FLAG_DIR_UNREAD = 8'h08;

  // Byte positions, common head of read and write
  localparam logic [7:0] POS_START   = 8'd1;
  localparam logic [7:0] POS_ID1     = 8'd2;
  localparam logic [7:0] POS_ID2     = 8'd3;
  localparam logic [7:0] POS_ADDR_HI = 8'd4;
  localparam logic [7:0] POS_ADDR_LO = 8'd5;

  // Read script
  localparam logic [7:0] RD_POS_ACK1    = 8'd6;
  localparam logic [7:0] RD_POS_ACK2    = 8'd7;
  localparam logic [7:0] RD_POS_ECHO_HI = 8'd8;
  localparam logic [7:0] RD_POS_ECHO_LO = 8'd9;
  localparam logic [7:0] RD_DATA_FIRST  = 8'd10;
  localparam logic [7:0] RD_DATA_END    = 8'(10 + SECTOR_BYTES);
  localparam logic [7:0] RD_POS_CSUM    = RD_DATA_END;
  localparam logic [7:0] RD_POS_END     = 8'(11 + SECTOR_BYTES);

  // Write script
  localparam logic [7:0] WR_DATA_FIRST = 8'd6;
  localparam logic [7:0] WR_DATA_END   = 8'(6 + SECTOR_BYTES);
  localparam logic [7:0] WR_POS_CSUM   = WR_DATA_END;
  localparam logic [7:0] WR_POS_ACK1   = 8'(7 + SECTOR_BYTES);
  localparam logic [7:0] WR_POS_ACK2   = 8'(8 + SECTOR_BYTES);
  localparam logic [7:0] WR_POS_END    = 8'(9 + SECTOR_BYTES);

  // Status script
  localparam logic [7:0] ST_POS_ACK1 = 8'd4;
  localparam logic [7:0] ST_POS_ACK2 = 8'd5;
  localparam logic [7:0] ST_POS_SIZE = 8'd6;
  localparam logic [7:0] ST_POS_Z1   = 8'd7;
  localparam logic [7:0] ST_POS_Z2   = 8'd8;
  localparam logic [7:0] ST_POS_END  = 8'd9;

endpackage
`default_nettype wire

// ===== rtl/memory_card_sector_protocol_unit.sv =====
// Channel | Dir | tdata (low bit up) | Other
// s_*     | in  | [7:0] host_byte    | -
// m_*     | out | [7:0] reply_byte   | tlast = transaction_end
//
// An item passes from the input register to the result register; a new item can be
// accepted every cycle once the store is cleared and while the output is not stalled.
// Sector data is read from the store one byte ahead, addressed from the state
// the next item will see, so the registered RAM read never stalls the flow.
// After reset the store is zeroed one byte a cycle, all SECTOR_BYTES * SECTOR_COUNT
// (131072) bytes of it; s_tready stays low until that is done.
// A stalled output holds its item; the input register still drains into it
// once it frees up.
`default_nettype none
module memory_card_sector_protocol_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] host_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] reply_byte
  output logic            m_tlast
);
  import mcspu_pkg::*;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;

  // Protocol state
  mode_t       mode, mode_next;
  logic [7:0]  pos, pos_next;
  logic [7:0]  csum, csum_next;
  logic [15:0] addr, addr_next;
  logic [7:0]  flag, flag_next;

  // Store clearing
  logic                clear_done;
  logic [STORE_AW-1:0] clr_cnt;

  // Store access
  logic                st_we;
  logic [STORE_AW-1:0] st_waddr;
  logic [7:0]          st_wdata;
  logic [STORE_AW-1:0] st_raddr;
  logic [7:0]          st_rdata;
  logic                wr_data_we;

  logic       proc_go;
  logic       addr_ok;
  logic [7:0] reply;
  logic       fin;
  logic [15:0] addr_eff;
  logic [7:0]  pos_eff;

  assign proc_go  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = clear_done && (!in_valid || proc_go);
  assign addr_ok  = addr < 16'(SECTOR_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // Reply and end of transaction for the item in the input register
  always_comb begin
    reply = RPL_BAD;
    fin   = 1'b0;
    case (mode)
      MODE_IDLE: begin
        if (in_byte == CMD_READ || in_byte == CMD_WRITE || in_byte == CMD_STATUS) begin
          reply = flag;
        end else begin
          fin = 1'b1;
        end
      end
      MODE_READ: begin
        case (pos)
          POS_ID1:        reply = RPL_ID1;
          POS_ID2:        reply = RPL_ID2;
          POS_ADDR_HI:    reply = RPL_ZERO;
          POS_ADDR_LO:    reply = RPL_ZERO;
          RD_POS_ACK1:    reply = RPL_ACK1;
          RD_POS_ACK2:    reply = RPL_ACK2;
          RD_POS_ECHO_HI: reply = addr[15:8];
          RD_POS_ECHO_LO: reply = addr[7:0];
          RD_POS_CSUM:    reply = csum;
          RD_POS_END: begin
            reply = RPL_GOOD;
            fin   = 1'b1;
          end
          default: begin
            if (pos >= RD_DATA_FIRST && pos < RD_DATA_END) begin
              reply = addr_ok ? st_rdata : RPL_BAD;
            end
          end
        endcase
      end
      MODE_WRITE: begin
        case (pos)
          POS_ID1:     reply = RPL_ID1;
          POS_ID2:     reply = RPL_ID2;
          POS_ADDR_HI: reply = RPL_ZERO;
          POS_ADDR_LO: reply = RPL_ZERO;
          WR_POS_CSUM: reply = csum;
          WR_POS_ACK1: reply = RPL_ACK1;
          WR_POS_ACK2: reply = RPL_ACK2;
          WR_POS_END: begin
            reply = addr_ok ? RPL_GOOD : RPL_BAD;
            fin   = 1'b1;
          end
          default: begin
            if (pos >= WR_DATA_FIRST && pos < WR_DATA_END) begin
              reply = RPL_ZERO;
            end
          end
        endcase
      end
      default: begin
        case (pos)
          POS_ID1:     reply = RPL_ID1;
          POS_ID2:     reply = RPL_ID2;
          ST_POS_ACK1: reply = RPL_ACK1;
          ST_POS_ACK2: reply = RPL_ACK2;
          ST_POS_SIZE: reply = RPL_SIZE;
          ST_POS_Z1:   reply = RPL_ZERO;
          ST_POS_Z2:   reply = RPL_ZERO;
          ST_POS_END: begin
            reply = RPL_TAIL;
            fin   = 1'b1;
          end
          default: reply = RPL_BAD;
        endcase
      end
    endcase
  end

  // Next protocol state for the item in the input register
  always_comb begin
    mode_next  = mode;
    pos_next   = pos + 8'd1;
    csum_next  = csum;
    addr_next  = addr;
    flag_next  = flag;
    wr_data_we = 1'b0;
    case (mode)
      MODE_IDLE: begin
        case (in_byte)
          CMD_READ:   mode_next = MODE_READ;
          CMD_WRITE:  mode_next = MODE_WRITE;
          CMD_STATUS: mode_next = MODE_STATUS;
          default:    mode_next = MODE_IDLE;
        endcase
      end
      MODE_READ: begin
        if (pos == POS_ADDR_HI) begin
          addr_next = {in_byte, addr[7:0]};
          csum_next = csum ^ in_byte;
        end else if (pos == POS_ADDR_LO) begin
          addr_next = {addr[15:8], in_byte};
          csum_next = csum ^ in_byte;
        end else if (pos >= RD_DATA_FIRST && pos < RD_DATA_END) begin
          csum_next = csum ^ (addr_ok ? st_rdata : RPL_BAD);
        end
      end
      MODE_WRITE: begin
        if (pos == POS_ADDR_HI) begin
          addr_next = {in_byte, addr[7:0]};
          csum_next = csum ^ in_byte;
        end else if (pos == POS_ADDR_LO) begin
          addr_next = {addr[15:8], in_byte};
          csum_next = csum ^ in_byte;
        end else if (pos >= WR_DATA_FIRST && pos < WR_DATA_END) begin
          csum_next  = csum ^ in_byte;
          wr_data_we = addr_ok;
        end else if (pos == WR_POS_END) begin
          flag_next = flag & ~FLAG_DIR_UNREAD;
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      mode_next = MODE_IDLE;
      pos_next  = POS_START;
      csum_next = 8'd0;
      addr_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pos  <= POS_START;
      csum <= 8'd0;
      addr <= 16'd0;
      flag <= FLAG_RESET;
    end else if (proc_go) begin
      mode <= mode_next;
      pos  <= pos_next;
      csum <= csum_next;
      addr <= addr_next;
      flag <= flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (proc_go) begin
      m_tdata <= reply;
      m_tlast <= fin;
    end
  end

  // Zero the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_done <= 1'b0;
      clr_cnt    <= '0;
    end else if (!clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == STORE_AW'(STORE_DEPTH - 1)) begin
        clear_done <= 1'b1;
      end
    end
  end

  // Prefetch the data byte for the state the next item will see
  assign addr_eff = proc_go ? addr_next : addr;
  assign pos_eff  = proc_go ? pos_next : pos;
  assign st_raddr = {addr_eff[SECT_W-1:0], OFF_W'(pos_eff - RD_DATA_FIRST)};

  always_comb begin
    if (!clear_done) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt;
      st_wdata = 8'd0;
    end else begin
      st_we    = proc_go && wr_data_we;
      st_waddr = {addr[SECT_W-1:0], OFF_W'(pos - WR_DATA_FIRST)};
      st_wdata = in_byte;
    end
  end

  mcspu_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/mcspu_ram.sv =====
`default_nettype none
module mcspu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/mcspu_checker.sv =====
`default_nettype none
`include "memory_card_sector_protocol_unit_assert.svh"
module mcspu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);
  import mcspu_pkg::*;

  `MCSPU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result item dropped while stalled")
  `MCSPU_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled result item changed")
  `MCSPU_ASSERT(a_end_byte, m_tvalid && m_tlast |-> m_tdata == RPL_GOOD || m_tdata == RPL_TAIL || m_tdata == RPL_BAD, "transaction ended on an unexpected reply")
  `MCSPU_ASSERT_ALWAYS(a_rst_out, rst |=> !m_tvalid, "result pending right after reset")
  `MCSPU_ASSERT_ALWAYS(a_rst_clear, rst |=> !s_tready, "input taken before the store was cleared")

endmodule

bind memory_card_sector_protocol_unit mcspu_checker u_mcspu_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
`default_nettype wire

// ===== tb/memory_card_sector_protocol_unit_tb.sv =====
`timescale 1ns / 100ps

module memory_card_sector_protocol_unit_tb;
  import mcspu_pkg::*;

  localparam int CYCLE_LIMIT = 2 * STORE_DEPTH + 400000;
  localparam int ITEM_TARGET = 700;

  typedef struct packed {
    logic [7:0] reply;
    logic       closes;
  } card_reply_t;

  // Card behavior: mode, script position, checksum, address, flag and sector data.
  class card_model;
    mode_t       mode;
    logic [7:0]  pos;
    logic [7:0]  csum;
    logic [15:0] addr;
    logic [7:0]  flag;
    bit   [7:0]  sectors [STORE_DEPTH];
    card_reply_t pending[$];
    int          mismatches;
    int          replies_checked;

    function new();
      mode = MODE_IDLE;
      pos = POS_START;
      csum = 8'h00;
      addr = 16'h0000;
      flag = FLAG_RESET;
      mismatches = 0;
      replies_checked = 0;
    endfunction

    function bit addr_in_range();
      return int'(addr) < SECTOR_COUNT;
    endfunction

    function void take_host_byte(logic [7:0] b);
      logic [7:0] r;
      logic       done;
      int         idx;
      r = RPL_BAD;
      done = 1'b0;
      case (mode)
        MODE_IDLE: begin
          if (b == CMD_READ) mode = MODE_READ;
          else if (b == CMD_WRITE) mode = MODE_WRITE;
          else if (b == CMD_STATUS) mode = MODE_STATUS;
          else done = 1'b1;
          r = done ? RPL_BAD : flag;
        end
        MODE_READ: begin
          case (pos)
            POS_ID1: r = RPL_ID1;
            POS_ID2: r = RPL_ID2;
            POS_ADDR_HI: begin
              addr[15:8] = b;
              csum ^= b;
              r = RPL_ZERO;
            end
            POS_ADDR_LO: begin
              addr[7:0] = b;
              csum ^= b;
              r = RPL_ZERO;
            end
            RD_POS_ACK1: r = RPL_ACK1;
            RD_POS_ACK2: r = RPL_ACK2;
            RD_POS_ECHO_HI: r = addr[15:8];
            RD_POS_ECHO_LO: r = addr[7:0];
            RD_POS_CSUM: r = csum;
            RD_POS_END: begin
              done = 1'b1;
              r = RPL_GOOD;
            end
            default: begin
              if (pos >= RD_DATA_FIRST && pos < RD_DATA_END) begin
                r = RPL_BAD;
                if (addr_in_range()) begin
                  idx = int'(addr) * SECTOR_BYTES + int'(pos - RD_DATA_FIRST);
                  r = sectors[idx];
                end
                csum ^= r;
              end
            end
          endcase
        end
        MODE_WRITE: begin
          case (pos)
            POS_ID1: r = RPL_ID1;
            POS_ID2: r = RPL_ID2;
            POS_ADDR_HI: begin
              addr[15:8] = b;
              csum ^= b;
              r = RPL_ZERO;
            end
            POS_ADDR_LO: begin
              addr[7:0] = b;
              csum ^= b;
              r = RPL_ZERO;
            end
            WR_POS_CSUM: r = csum;
            WR_POS_ACK1: r = RPL_ACK1;
            WR_POS_ACK2: r = RPL_ACK2;
            WR_POS_END: begin
              done = 1'b1;
              flag &= ~FLAG_DIR_UNREAD;
              r = addr_in_range() ? RPL_GOOD : RPL_BAD;
            end
            default: begin
              if (pos >= WR_DATA_FIRST && pos < WR_DATA_END) begin
                if (addr_in_range()) begin
                  idx = int'(addr) * SECTOR_BYTES + int'(pos - WR_DATA_FIRST);
                  sectors[idx] = b;
                end
                csum ^= b;
                r = RPL_ZERO;
              end
            end
          endcase
        end
        default: begin
          case (pos)
            POS_ID1: r = RPL_ID1;
            POS_ID2: r = RPL_ID2;
            ST_POS_ACK1: r = RPL_ACK1;
            ST_POS_ACK2: r = RPL_ACK2;
            ST_POS_SIZE: r = RPL_SIZE;
            ST_POS_Z1: r = RPL_ZERO;
            ST_POS_Z2: r = RPL_ZERO;
            ST_POS_END: begin
              done = 1'b1;
              r = RPL_TAIL;
            end
            default: r = RPL_BAD;
          endcase
        end
      endcase
      // End of transaction drops back to idle with a fresh script.
      if (done) begin
        mode = MODE_IDLE;
        pos = POS_START;
        csum = 8'h00;
        addr = 16'h0000;
      end else begin
        pos = pos + 8'd1;
      end
      pending.push_back('{reply: r, closes: done});
    endfunction

    function void check_reply(logic [7:0] data, logic last);
      card_reply_t exp;
      if (pending.size() == 0) begin
        $error("reply_byte: no reply expected, got %h (tlast %b)", data, last);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      replies_checked++;
      if (data !== exp.reply) begin
        $error("reply_byte: expected %h, got %h", exp.reply, data);
        mismatches++;
      end
      if (last !== exp.closes) begin
        $error("transaction_end: expected %b, got %b", exp.closes, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  card_model card = new();

  int send_idle_pct = 13;
  int recv_idle_pct = 86;
  int items_sent = 0;
  int cycle_count = 0;
  int n_read = 0;
  int n_write = 0;
  int n_status = 0;
  int n_unknown = 0;

  memory_card_sector_protocol_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("memory_card_sector_protocol_unit_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) card.check_reply(m_tdata, m_tlast);
  end

  // Starts and ends at a falling edge; valid stays high between back-to-back items.
  task automatic send_byte(input logic [7:0] b);
    if (items_sent < 250) begin
      send_idle_pct = 13;
      recv_idle_pct = 86;
    end else if (items_sent < 500) begin
      send_idle_pct = 86;
      recv_idle_pct = 13;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    card.take_host_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_unknown_mode(input logic [7:0] b);
    n_unknown++;
    send_byte(b);
  endtask

  // Full script for one mode; filler and data positions carry random bytes.
  task automatic run_transaction(input mode_t kind, input logic [15:0] sect);
    logic [7:0] last_pos;
    logic [7:0] cmd;
    logic [7:0] b;
    case (kind)
      MODE_READ: begin
        last_pos = RD_POS_END;
        cmd = CMD_READ;
        n_read++;
      end
      MODE_WRITE: begin
        last_pos = WR_POS_END;
        cmd = CMD_WRITE;
        n_write++;
      end
      default: begin
        last_pos = ST_POS_END;
        cmd = CMD_STATUS;
        n_status++;
      end
    endcase
    for (int p = POS_START; p <= last_pos; p++) begin
      if (p == POS_START) b = cmd;
      else if (kind != MODE_STATUS && p == POS_ADDR_HI) b = sect[15:8];
      else if (kind != MODE_STATUS && p == POS_ADDR_LO) b = sect[7:0];
      else b = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  function automatic logic [15:0] pick_sector();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'(SECTOR_COUNT - 1);
      2: return 16'($urandom_range(SECTOR_COUNT - 1));
      default: return 16'($urandom_range(16'hffff, SECTOR_COUNT));
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CMD_READ || b == CMD_WRITE || b == CMD_STATUS) b = 8'($urandom_range(255));
    return b;
  endfunction

  initial begin
    int pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unknown mode bytes at the extremes and next to the command codes.
    send_unknown_mode(8'h00);
    send_unknown_mode(8'hff);
    send_unknown_mode(8'h51);
    send_unknown_mode(8'h54);
    send_unknown_mode(8'h58);
    // Status before any write shows the directory-unread flag.
    run_transaction(MODE_STATUS, 16'h0000);

    // Last sector written then read back, then both beyond the store.
    run_transaction(MODE_WRITE, 16'(SECTOR_COUNT - 1));
    run_transaction(MODE_READ, 16'(SECTOR_COUNT - 1));
    run_transaction(MODE_WRITE, 16'hffff);
    run_transaction(MODE_READ, 16'(SECTOR_COUNT));

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 20) send_unknown_mode(pick_noise());
      else if (pick < 60) run_transaction(MODE_STATUS, 16'h0000);
      else if (pick < 80) run_transaction(MODE_WRITE, pick_sector());
      else run_transaction(MODE_READ, pick_sector());
    end
    s_tvalid <= 1'b0;

    while (card.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d host bytes: %0d read, %0d write, %0d status transactions, %0d unknown modes.",
             items_sent, n_read, n_write, n_status, n_unknown);
    $display("Checked %0d replies under three sender/receiver stall mixes, %0d mismatches.",
             card.replies_checked, card.mismatches);
    if (card.mismatches == 0 && card.pending.size() == 0) begin
      $display("memory_card_sector_protocol_unit_tb: clean");
    end else begin
      $display("memory_card_sector_protocol_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcspu_pkg.sv
rtl/mcspu_ram.sv
rtl/memory_card_sector_protocol_unit.sv
rtl/mcspu_checker.sv
tb/memory_card_sector_protocol_unit_tb.sv
